@@ hw/rtl/two_wire_seven_segment_driver_top_assert.svh @@
// Assertion macros shared by the display driver RTL.
`ifndef TWO_WIRE_SEVEN_SEGMENT_DRIVER_TOP_ASSERT_SVH
`define TWO_WIRE_SEVEN_SEGMENT_DRIVER_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TW7_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define TW7_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after the antecedent holds.
`define TW7_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tw7seg_pkg.sv @@
package tw7seg_pkg;

  localparam int unsigned NumberW = 14;
  localparam int unsigned BrightW = 3;

  localparam logic [1:0] CmdTick   = 2'd0;
  localparam logic [1:0] CmdShow   = 2'd1;
  localparam logic [1:0] CmdBright = 2'd2;

  localparam logic [7:0] DataCmdByte = 8'h40;
  localparam logic [7:0] AddrCmdByte = 8'hC0;
  localparam logic [7:0] CtrlCmdByte = 8'h88;

  localparam logic [2:0] LastPos  = 3'd6;
  localparam logic [2:0] ResetBright = 3'd4;

  // Reciprocals of 10, 100 and 1000, scaled by 2^19, 2^19 and 2^23 and rounded up.
  localparam logic [15:0] Recip10   = 16'd52429;
  localparam logic [12:0] Recip100  = 13'd5243;
  localparam logic [13:0] Recip1000 = 14'd8389;

  typedef logic [7:0] byte_t;

  function automatic byte_t seg_of(input logic [3:0] digit);
    byte_t seg;
    case (digit)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

@@ hw/rtl/two_wire_seven_segment_driver_top.sv @@
// Two-wire seven-segment display driver.
// The input stream carries one beat per command: tuser holds the command
// (tick, show number, send brightness) and tdata holds the number to show.
// Every accepted beat produces exactly one output beat carrying the clock
// level, data drive enable, data level and a busy flag for that slot.
// A show or brightness command accepted while idle queues its frames and
// sets busy; each following tick beat emits one pin slot until the last
// stop slot. Commands arriving while busy are dropped.
// The output beat appears in the cycle after its input beat. One beat is
// accepted every cycle unless the receiver stalls; the output register lets
// a new beat in while the previous result is taken in the same cycle.
// When the receiver stalls, the result stays in the output register and
// tready falls until it is taken.
// The four decimal digits are split out by reciprocal multiplication in the
// cycle that takes the show command, so the conversion is combinational. Reset
// leaves the block idle, clock low, data driven low, brightness register at 4.
// The cfg port must write brightness only while idle; the block does not check.
module two_wire_seven_segment_driver_top
  import tw7seg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // number[13:0], zero pad
  input  logic [1:0]         s_axis_tuser,  // command[1:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // clock_level, data_driven, data_level,
                                            // busy_res, zero pad
  input  logic               cfg_we_i,
  input  logic [BrightW-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    PhIdle,
    PhStart,
    PhBits,
    PhAck,
    PhStop
  } phase_e;

  phase_e phase_q, phase_d;
  logic [2:0] pos_q, pos_d;
  logic [3:0] cnt_q, cnt_d;
  logic clk_q, clk_d;
  logic dat_q, dat_d;
  logic drv_q, drv_d;
  logic busy_q, busy_d;
  logic [BrightW-1:0] bright_q;
  logic [BrightW-1:0] bright_lat_q, bright_lat_d;

  logic [29:0] prod10;
  logic [26:0] prod100;
  logic [27:0] prod1000;
  logic [10:0] quo10;
  logic [7:0]  quo100;
  logic [4:0]  quo1000;
  logic [3:0]  dig_unit;
  logic [3:0]  dig_ten;
  logic [3:0]  dig_hund;
  logic [3:0]  dig_thou;
  logic [15:0] digits_q, digits_d;

  logic m_valid_q;
  logic [3:0] m_data_q;
  logic [3:0] res_d;

  logic in_acc;
  logic [1:0] cmd;
  logic [NumberW-1:0] number;
  byte_t cur_byte;
  logic cur_bit;
  logic frame_ends;
  logic load_show;
  logic emitted_busy;

  assign cmd    = s_axis_tuser;
  assign number = s_axis_tdata[NumberW-1:0];
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_data_q};

  assign prod10   = 30'(number) * 30'(Recip10);
  assign prod100  = 27'(number) * 27'(Recip100);
  assign prod1000 = 28'(number) * 28'(Recip1000);
  assign quo10    = prod10[29:19];
  assign quo100   = prod100[26:19];
  assign quo1000  = prod1000[27:23];

  assign dig_unit = 4'(number - NumberW'(quo10) * NumberW'(10));
  assign dig_ten  = 4'(quo10 - 11'(quo100) * 11'd10);
  assign dig_hund = 4'(quo100 - 8'(quo1000) * 8'd10);
  assign dig_thou = (quo1000 >= 5'd10) ? 4'(quo1000 - 5'd10) : quo1000[3:0];
  assign digits_d = {dig_thou, dig_hund, dig_ten, dig_unit};

  always_comb begin
    unique case (pos_q)
      3'd0: cur_byte = DataCmdByte;
      3'd1: cur_byte = AddrCmdByte;
      3'd2: cur_byte = seg_of(digits_q[15:12]);
      3'd3: cur_byte = seg_of(digits_q[11:8]);
      3'd4: cur_byte = seg_of(digits_q[7:4]);
      3'd5: cur_byte = seg_of(digits_q[3:0]);
      default: cur_byte = CtrlCmdByte | {5'b00000, bright_lat_q};
    endcase
  end

  assign cur_bit    = cur_byte[cnt_q[3:1]];
  assign frame_ends = (pos_q == 3'd0) || (pos_q == 3'd5) || (pos_q >= LastPos);

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    clk_d        = clk_q;
    dat_d        = dat_q;
    drv_d        = drv_q;
    busy_d       = busy_q;
    bright_lat_d = bright_lat_q;
    load_show    = 1'b0;
    emitted_busy = busy_q;

    if (cmd == CmdTick) begin
      if (busy_q) begin
        unique case (phase_q)
          PhStart: begin
            clk_d = 1'b1;
            drv_d = 1'b1;
            if (cnt_q == 4'd0) begin
              dat_d = 1'b1;
              cnt_d = 4'd1;
            end else begin
              dat_d   = 1'b0;
              phase_d = PhBits;
              cnt_d   = 4'd0;
            end
          end
          PhBits: begin
            clk_d = cnt_q[0];
            drv_d = 1'b1;
            dat_d = cur_bit;
            if (cnt_q == 4'd15) begin
              phase_d = PhAck;
              cnt_d   = 4'd0;
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end
          PhAck: begin
            clk_d = (cnt_q == 4'd2);
            drv_d = (cnt_q == 4'd0);
            if (cnt_q >= 4'd3) begin
              cnt_d = 4'd0;
              if (frame_ends) begin
                phase_d = PhStop;
              end else begin
                pos_d   = pos_q + 3'd1;
                phase_d = PhBits;
              end
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end
          PhStop: begin
            drv_d = 1'b1;
            if (cnt_q == 4'd0) begin
              clk_d = 1'b1;
              dat_d = 1'b0;
              cnt_d = 4'd1;
            end else if (cnt_q == 4'd1) begin
              clk_d = 1'b1;
              dat_d = 1'b1;
              cnt_d = 4'd2;
            end else begin
              clk_d = 1'b0;
              dat_d = 1'b1;
              cnt_d = 4'd0;
              if (pos_q >= LastPos) begin
                phase_d = PhIdle;
              end else begin
                pos_d   = pos_q + 3'd1;
                phase_d = PhStart;
              end
            end
          end
          default: begin
            phase_d = PhIdle;
            cnt_d   = 4'd0;
          end
        endcase
        emitted_busy = 1'b1;
        busy_d       = (phase_d != PhIdle);
      end else begin
        emitted_busy = 1'b0;
      end
    end else if (!busy_q && (cmd == CmdShow || cmd == CmdBright)) begin
      load_show    = (cmd == CmdShow);
      bright_lat_d = bright_q;
      pos_d        = (cmd == CmdShow) ? 3'd0 : LastPos;
      cnt_d        = 4'd0;
      phase_d      = PhStart;
      busy_d       = 1'b1;
      emitted_busy = 1'b1;
    end

    res_d = {emitted_busy, drv_d & dat_d, drv_d, clk_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      pos_q        <= 3'd0;
      cnt_q        <= 4'd0;
      clk_q        <= 1'b0;
      dat_q        <= 1'b0;
      drv_q        <= 1'b1;
      busy_q       <= 1'b0;
      bright_q     <= ResetBright;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bright_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        cnt_q     <= cnt_d;
        clk_q     <= clk_d;
        dat_q     <= dat_d;
        drv_q     <= drv_d;
        busy_q    <= busy_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bright_lat_q <= bright_lat_d;
      m_data_q     <= res_d;
      if (load_show) begin
        digits_q <= digits_d;
      end
    end
  end

  `include "two_wire_seven_segment_driver_top_assert.svh"

  `TW7_ASSERT(a_busy_matches_phase, busy_q == (phase_q != PhIdle),
              "Busy flag disagrees with frame phase.")
  `TW7_ASSERT_IMPL(a_digit_in_range,
                   phase_q == PhBits && pos_q >= 3'd2 && pos_q <= 3'd5,
                   cur_byte != 8'h00,
                   "Digit byte holds no decimal digit.")
  `TW7_ASSERT_IMPL(a_ack_count, phase_q == PhAck || phase_q == PhStop,
                   cnt_q <= 4'd3 && pos_q <= LastPos,
                   "Slot counter or byte position out of range.")
  `TW7_ASSERT_NEXT(a_stall_holds_result, m_valid_q && !m_axis_tready,
                   m_valid_q && $stable(m_data_q) && $stable(phase_q),
                   "Stalled result or state changed.")

endmodule
